FILE: rtl/core/sphere_pair_impact_time_top_defines.svh
// Assertion macros shared by the sphere pair impact time block
`ifndef SPHERE_PAIR_IMPACT_TIME_TOP_DEFINES_SVH
`define SPHERE_PAIR_IMPACT_TIME_TOP_DEFINES_SVH

// condition implies consequence on the same edge
`define SPIT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence on the following edge
`define SPIT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/spit_pkg.sv
package spit_pkg;
    localparam int DW = 32;
    localparam int RW = DW - 1;
    localparam int EW = DW + 1;
    localparam int TW = 32;
    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd4295;

    // commands from controller to datapath
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic mac;
        logic [3:0] mac_sel;
        logic fin_coef;
        logic disc_mul;
        logic disc_step;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic take_root;
        logic clr_res;
    } spit_cmd_t;

    typedef struct packed {
        logic linear;
        logic disc_neg;
        logic lin_ok;
        logic root_ok;
    } spit_sts_t;
endpackage

FILE: rtl/core/sphere_pair_impact_time_top.sv
// An op 1 beat gives a result after the multiply-accumulate steps; the linear path ends
// there when it finds no contact, or runs one division on a linear contact; the quadratic
// path runs the discriminant, the square root and one division per accepted root.
// Op 0 beats give no result. One item is in flight at a time; the
// next beat is taken the cycle after the result beat.
// Reset (rst_n, async low) clears sphere A to zero, threshold to 4295, no result.
module sphere_pair_impact_time_top
    import spit_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic signed [DW-1:0] pos_x,
    input  logic signed [DW-1:0] pos_y,
    input  logic signed [DW-1:0] pos_z,
    input  logic signed [DW-1:0] vel_x,
    input  logic signed [DW-1:0] vel_y,
    input  logic signed [DW-1:0] vel_z,
    input  logic signed [DW-1:0] acc_x,
    input  logic signed [DW-1:0] acc_y,
    input  logic signed [DW-1:0] acc_z,
    input  logic [RW-1:0]        sphere_radius,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 collided,
    output logic [TW-1:0]        time_offset,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [THR_W-1:0]     cfg_data
);
    spit_cmd_t cmd;
    spit_sts_t sts;
    logic [5:0] step;
    logic root_idx;
    logic [THR_W-1:0] thr_reg;
    logic hit;
    logic [TW-1:0] tm;

    // threshold register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) thr_reg <= THR_RESET;
        else if (cfg_valid) thr_reg <= cfg_data;
    end

    assign collided = hit;
    assign time_offset = hit ? tm : '0;

    spit_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_op(op), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd),
        .step(step), .root_idx(root_idx)
    );

    spit_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .step(step[2:0]), .root_idx(root_idx),
        .thr(thr_reg), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
        .sphere_radius(sphere_radius), .sts(sts), .res_hit(hit), .res_time(tm)
    );
endmodule

FILE: rtl/core/spit_datapath.sv
module spit_datapath
    import spit_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  spit_cmd_t              cmd,
    input  logic [2:0]             step,
    input  logic                   root_idx,
    input  logic [THR_W-1:0]       thr,
    input  logic signed [DW-1:0]   pos_x,
    input  logic signed [DW-1:0]   pos_y,
    input  logic signed [DW-1:0]   pos_z,
    input  logic signed [DW-1:0]   vel_x,
    input  logic signed [DW-1:0]   vel_y,
    input  logic signed [DW-1:0]   vel_z,
    input  logic signed [DW-1:0]   acc_x,
    input  logic signed [DW-1:0]   acc_y,
    input  logic signed [DW-1:0]   acc_z,
    input  logic [RW-1:0]          sphere_radius,
    output spit_sts_t              sts,
    output logic                   res_hit,
    output logic [TW-1:0]          res_time
);
    // held sphere A
    logic signed [DW-1:0] hp_reg [3];
    logic signed [DW-1:0] hv_reg [3];
    logic signed [DW-1:0] ha_reg [3];
    logic [RW-1:0]        hr_reg;
    // relative vectors
    logic signed [EW-1:0] sd_reg [3];
    logic signed [EW-1:0] vd_reg [3];
    logic signed [EW-1:0] ad_reg [3];
    logic [DW-1:0]        rs_reg;
    // exact accumulators
    logic signed [71:0] aw_reg, hw_reg, cw_reg;
    logic signed [63:0] a_reg, h_reg, c_reg;
    logic signed [128:0] disc_reg;
    logic [65:0] sr_reg;
    logic [63:0] sq_reg;
    // divider
    logic [127:0] dn_reg;
    logic [63:0]  dr_reg;
    logic [63:0]  dd_reg;
    logic [127:0] dq_reg;
    logic         hit_reg;
    logic [TW-1:0] t_reg;

    logic signed [EW-1:0] mx, my;
    logic signed [2*EW-1:0] prod;
    logic [1:0] ix;

    // operand select for the shared multiplier
    always_comb
    begin
        ix = 2'(cmd.mac_sel[3:2]);
        if (ix == 2'd3) ix = 2'd0;
        unique case (cmd.mac_sel[1:0])
            2'd0: begin mx = sd_reg[ix]; my = ad_reg[ix]; end
            2'd1: begin mx = vd_reg[ix]; my = vd_reg[ix]; end
            2'd2: begin mx = sd_reg[ix]; my = vd_reg[ix]; end
            default: begin mx = sd_reg[ix]; my = sd_reg[ix]; end
        endcase
        if (cmd.mac_sel[3:2] == 2'd3)
        begin
            mx = $signed({1'b0, rs_reg});
            my = $signed({1'b0, rs_reg});
        end
        prod = mx * my;
    end

    function automatic logic signed [63:0] sat(input logic signed [71:0] v);
        if (v > 72'sh007fffffffffffffff) return 64'sh7fffffffffffffff;
        if (v < -72'sh0080000000000000_00) return {1'b1, 63'd0};
        return v[63:0];
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    logic [63:0] am, hm, cm;
    logic signed [65:0] mh, num;
    logic [65:0] numa;
    logic small_h;
    logic [63:0] px, py;
    logic [31:0] pa, pb;
    logic [63:0] pp;
    logic [128:0] pterm;
    logic p_sub;
    logic [67:0] rt_cur, rt_trial;
    assign am = mag(a_reg);
    assign hm = mag(h_reg);
    assign cm = mag(c_reg);
    assign mh = -66'(h_reg);
    assign num = root_idx ? mh - $signed({2'b0, sq_reg}) : mh + $signed({2'b0, sq_reg});
    assign numa = num[65] ? 66'(-num) : 66'(num);
    assign small_h = (h_reg == 0) || (hm < 64'd32768 && (hm << 1) < 64'(thr));

    // discriminant slice: step[2] picks h*h or a*c, step[1:0] the 32-bit halves
    always_comb
    begin
        px = step[2] ? am : hm;
        py = step[2] ? cm : hm;
        pa = step[0] ? px[63:32] : px[31:0];
        pb = step[1] ? py[63:32] : py[31:0];
        pp = pa * pb;
        unique case (step[1:0])
            2'd0: pterm = 129'(pp);
            2'd1, 2'd2: pterm = 129'(pp) << 32;
            default: pterm = 129'(pp) << 64;
        endcase
        // a*c is positive when the signs agree, so it comes off
        p_sub = step[2] && (a_reg[63] == c_reg[63]);
    end

    // square root: two radicand bits in, one root bit out
    assign rt_cur = {sr_reg, disc_reg[127:126]};
    assign rt_trial = {2'b00, sq_reg, 2'b01};

    assign sts.linear = (a_reg == 0) || (am < 64'(thr));
    assign sts.disc_neg = disc_reg[128];
    assign sts.lin_ok = !small_h && c_reg != 0 && (c_reg[63] != h_reg[63]);
    assign sts.root_ok = num != 0 && (num[65] == a_reg[63]);
    assign res_hit = hit_reg;
    assign res_time = t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hp_reg[i] <= '0; hv_reg[i] <= '0; ha_reg[i] <= '0;
                sd_reg[i] <= '0; vd_reg[i] <= '0; ad_reg[i] <= '0;
            end
            hr_reg <= '0;
            rs_reg <= '0;
            aw_reg <= '0; hw_reg <= '0; cw_reg <= '0;
            a_reg <= '0; h_reg <= '0; c_reg <= '0;
            disc_reg <= '0; sr_reg <= '0; sq_reg <= '0;
            dn_reg <= '0; dr_reg <= '0; dd_reg <= '0; dq_reg <= '0;
            hit_reg <= 1'b0;
            t_reg <= '0;
        end
        else
        begin
            if (cmd.load_a)
            begin
                hp_reg[0] <= pos_x; hp_reg[1] <= pos_y; hp_reg[2] <= pos_z;
                hv_reg[0] <= vel_x; hv_reg[1] <= vel_y; hv_reg[2] <= vel_z;
                ha_reg[0] <= acc_x; ha_reg[1] <= acc_y; ha_reg[2] <= acc_z;
                hr_reg <= sphere_radius;
            end
            // relative vectors, clear accumulators
            if (cmd.load_b)
            begin
                sd_reg[0] <= EW'(pos_x) - EW'(hp_reg[0]);
                sd_reg[1] <= EW'(pos_y) - EW'(hp_reg[1]);
                sd_reg[2] <= EW'(pos_z) - EW'(hp_reg[2]);
                vd_reg[0] <= EW'(vel_x) - EW'(hv_reg[0]);
                vd_reg[1] <= EW'(vel_y) - EW'(hv_reg[1]);
                vd_reg[2] <= EW'(vel_z) - EW'(hv_reg[2]);
                ad_reg[0] <= EW'(acc_x) - EW'(ha_reg[0]);
                ad_reg[1] <= EW'(acc_y) - EW'(ha_reg[1]);
                ad_reg[2] <= EW'(acc_z) - EW'(ha_reg[2]);
                rs_reg <= DW'(hr_reg) + DW'(sphere_radius);
                aw_reg <= '0; hw_reg <= '0; cw_reg <= '0;
            end
            // accumulate one product a cycle
            if (cmd.mac)
            begin
                if (cmd.mac_sel[3:2] == 2'd3)
                    cw_reg <= cw_reg - 72'(prod);
                else
                    unique case (cmd.mac_sel[1:0])
                        2'd0, 2'd1: aw_reg <= aw_reg + 72'(prod);
                        2'd2: hw_reg <= hw_reg + 72'(prod);
                        default: cw_reg <= cw_reg + 72'(prod);
                    endcase
            end
            if (cmd.fin_coef)
            begin
                a_reg <= sat(aw_reg); h_reg <= sat(hw_reg); c_reg <= sat(cw_reg);
            end
            // clear discriminant and root
            if (cmd.disc_mul)
            begin
                disc_reg <= '0;
                sr_reg <= '0;
                sq_reg <= '0;
            end
            // discriminant from eight partial products, one a cycle
            if (cmd.disc_step)
                disc_reg <= p_sub ? disc_reg - $signed(pterm) : disc_reg + $signed(pterm);
            // one square root bit a cycle
            if (cmd.sqrt_step)
            begin
                if (rt_cur >= rt_trial)
                begin
                    sr_reg <= 66'(rt_cur - rt_trial);
                    sq_reg <= {sq_reg[62:0], 1'b1};
                end
                else
                begin
                    sr_reg <= rt_cur[65:0];
                    sq_reg <= {sq_reg[62:0], 1'b0};
                end
                disc_reg <= disc_reg << 2;
            end
            if (cmd.clr_res)
            begin
                hit_reg <= 1'b0; t_reg <= '0;
            end
            if (cmd.div_init)
            begin
                dr_reg <= '0; dq_reg <= '0;
                if (sts.linear)
                begin
                    dn_reg <= 128'(cm) << 15; dd_reg <= hm;
                end
                else
                begin
                    dn_reg <= 128'(numa) << 16; dd_reg <= am;
                end
            end
            // two quotient bits a cycle
            if (cmd.div_step)
            begin
                logic [64:0] r1, r2;
                logic q1, q2;
                r1 = {dr_reg, dn_reg[127]};
                q1 = r1 >= 65'(dd_reg);
                if (q1) r1 = r1 - 65'(dd_reg);
                r2 = {r1[63:0], dn_reg[126]};
                q2 = r2 >= 65'(dd_reg);
                if (q2) r2 = r2 - 65'(dd_reg);
                dr_reg <= r2[63:0];
                dn_reg <= dn_reg << 2;
                dq_reg <= {dq_reg[125:0], q1, q2};
            end
            if (cmd.take_root)
            begin
                logic [TW-1:0] ti;
                ti = (dd_reg == 0 || dq_reg[127:32] != 0) ? '1 : dq_reg[31:0];
                if (!hit_reg || ti < t_reg) t_reg <= ti;
                hit_reg <= 1'b1;
            end
        end
    end
endmodule

FILE: rtl/core/spit_ctrl.sv
module spit_ctrl
    import spit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_op,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  spit_sts_t  sts,
    output spit_cmd_t  cmd,
    output logic [5:0] step,
    output logic       root_idx
);
`include "sphere_pair_impact_time_top_defines.svh"
    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_FIN, S_DECIDE, S_DISC, S_SQRT, S_DINIT, S_DIV, S_TAKE, S_NEXT, S_OUT
    } state_t;

    state_t state_reg;
    logic [5:0] step_reg;
    logic root_reg;
    logic out_valid_reg;
    logic accept;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign step = step_reg;
    assign root_idx = root_reg;

    // command decode
    always_comb
    begin
        cmd = '0;
        cmd.load_a = accept && !in_op;
        cmd.load_b = accept && in_op;
        cmd.clr_res = accept && in_op;
        cmd.mac = state_reg == S_MAC;
        cmd.mac_sel = step_reg[3:0];
        cmd.fin_coef = state_reg == S_FIN;
        cmd.disc_mul = state_reg == S_DECIDE && !sts.linear;
        cmd.disc_step = state_reg == S_DISC;
        cmd.sqrt_step = state_reg == S_SQRT;
        cmd.div_init = state_reg == S_DINIT;
        cmd.div_step = state_reg == S_DIV;
        cmd.take_root = state_reg == S_TAKE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            root_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (accept && in_op)
                    begin
                        state_reg <= S_MAC; step_reg <= '0;
                    end
                // mac_sel: [3:2] axis (3 = radius), [1:0] product kind
                S_MAC:
                    if (step_reg == 6'd12) state_reg <= S_FIN;
                    else if (step_reg[3:2] == 2'd2 && step_reg[1:0] == 2'd3)
                        step_reg <= 6'd12;
                    else step_reg <= step_reg + 6'd1;
                S_FIN: state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    root_reg <= 1'b0;
                    step_reg <= '0;
                    if (sts.linear) state_reg <= sts.lin_ok ? S_DINIT : S_OUT;
                    else state_reg <= S_DISC;
                end
                // eight partial products for the discriminant
                S_DISC:
                    if (step_reg == 6'd7)
                    begin
                        step_reg <= '0; state_reg <= S_SQRT;
                    end
                    else step_reg <= step_reg + 6'd1;
                S_SQRT:
                    if (step_reg == 6'd0 && sts.disc_neg) state_reg <= S_OUT;
                    else if (step_reg == 6'd63) state_reg <= S_NEXT;
                    else step_reg <= step_reg + 6'd1;
                S_NEXT:
                    if (sts.root_ok) state_reg <= S_DINIT;
                    else if (root_reg) state_reg <= S_OUT;
                    else root_reg <= 1'b1;
                S_DINIT:
                begin
                    step_reg <= '0; state_reg <= S_DIV;
                end
                S_DIV:
                    if (step_reg == 6'd63) state_reg <= S_TAKE;
                    else step_reg <= step_reg + 6'd1;
                S_TAKE:
                    if (sts.linear || root_reg) state_reg <= S_OUT;
                    else
                    begin
                        root_reg <= 1'b1; state_reg <= S_NEXT;
                    end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1; state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SPIT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, in_stall, "accept while busy")
    `SPIT_ASSERT_NXT(a_out_follows, clk, rst_n, state_reg == S_OUT, out_valid_reg, "result lost")
    `SPIT_ASSERT_IMP(a_div_excl, clk, rst_n, cmd.div_step, !cmd.sqrt_step && !cmd.mac, "unit overlap")
endmodule

FILE: tb/sv/sphere_pair_impact_time_checker.sv
`timescale 1ns / 1ps

module sphere_pair_impact_time_checker
    import spit_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 op,
    input  logic signed [DW-1:0] pos_x,
    input  logic signed [DW-1:0] pos_y,
    input  logic signed [DW-1:0] pos_z,
    input  logic signed [DW-1:0] vel_x,
    input  logic signed [DW-1:0] vel_y,
    input  logic signed [DW-1:0] vel_z,
    input  logic signed [DW-1:0] acc_x,
    input  logic signed [DW-1:0] acc_y,
    input  logic signed [DW-1:0] acc_z,
    input  logic [RW-1:0]        sphere_radius,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 collided,
    input  logic [TW-1:0]        time_offset,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [THR_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending_hits
);
    localparam logic OP_STORE_A = 1'b0;
    localparam logic OP_SOLVE_B = 1'b1;
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef struct packed {
        logic          hit;
        logic [TW-1:0] toi;
    } impact_t;

    impact_t impact_q[$];

    // sphere A and threshold as held by the predictor
    logic signed [DW-1:0] a_pos[3];
    logic signed [DW-1:0] a_vel[3];
    logic signed [DW-1:0] a_acc[3];
    logic [RW-1:0]        a_rad;
    logic [THR_W-1:0]     thr;

    function automatic logic signed [63:0] sat_q32(input logic signed [127:0] v);
        if (v > 128'sd0 + S64_MAX) return S64_MAX;
        if (v < 128'sd0 + S64_MIN) return S64_MIN;
        return v[63:0];
    endfunction

    // floor(n/d) clamped to 32 bits
    function automatic logic [31:0] div_sat(input logic [191:0] n, input logic [63:0] d);
        logic [191:0] q;
        if (d == 0) return '1;
        q = n / d;
        if (q > 192'hFFFF_FFFF) return '1;
        return q[31:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    function automatic impact_t solve_impact(input logic signed [DW-1:0] p[3],
                                             input logic signed [DW-1:0] v[3],
                                             input logic signed [DW-1:0] ac[3],
                                             input logic [RW-1:0] rb);
        logic signed [127:0] aw, hw, cw, disc, mh, s, num;
        logic signed [63:0]  sd, vd, ad, ca, ch, cc;
        logic [63:0]         rsum, ma, mh64;
        logic [31:0]         ti;
        impact_t             res;
        aw = 0; hw = 0; cw = 0;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            sd = 64'(p[i]) - 64'(a_pos[i]);
            vd = 64'(v[i]) - 64'(a_vel[i]);
            ad = 64'(ac[i]) - 64'(a_acc[i]);
            aw += 128'(sd) * 128'(ad) + 128'(vd) * 128'(vd);
            hw += 128'(sd) * 128'(vd);
            cw += 128'(sd) * 128'(sd);
        end
        rsum = 64'(a_rad) + 64'(rb);
        cw -= $signed({64'd0, rsum} * {64'd0, rsum});
        ca = sat_q32(aw);
        ch = sat_q32(hw);
        cc = sat_q32(cw);
        ma = ca < 0 ? -ca : ca;
        mh64 = ch < 0 ? -ch : ch;
        if (ca == 0 || ma < 64'(thr))
        begin
            // linear fallback; tiny h means no answer
            if (!(ch == 0 || (mh64 < 32768 && 2 * mh64 < 64'(thr)))
                && cc != 0 && ((cc < 0) != (ch < 0)))
            begin
                res.hit = 1'b1;
                res.toi = div_sat({128'd0, (cc < 0 ? -cc : cc)} << 15, mh64);
            end
        end
        else
        begin
            disc = 128'(ch) * 128'(ch) - 128'(ca) * 128'(cc);
            if (disc >= 0)
            begin
                s = $signed({64'd0, root_floor(disc)});
                mh = -128'(ch);
                for (int k = 0; k < 2; k++)
                begin
                    num = k == 0 ? mh + s : mh - s;
                    if (num != 0 && ((num < 0) == (ca < 0)))
                    begin
                        ti = div_sat({64'd0, (num < 0 ? -num : num)} << 16, ma);
                        if (!res.hit || ti < res.toi) res.toi = ti;
                        res.hit = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    assign pending_hits = impact_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        impact_t got, want;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_pos[i] <= '0;
                a_vel[i] <= '0;
                a_acc[i] <= '0;
            end
            a_rad <= '0;
            thr <= THR_RESET;
            fail_count <= 0;
            impact_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready) thr <= cfg_data;
            // input beat
            if (in_valid && !in_stall)
            begin
                if (op == OP_STORE_A)
                begin
                    a_pos[0] <= pos_x; a_pos[1] <= pos_y; a_pos[2] <= pos_z;
                    a_vel[0] <= vel_x; a_vel[1] <= vel_y; a_vel[2] <= vel_z;
                    a_acc[0] <= acc_x; a_acc[1] <= acc_y; a_acc[2] <= acc_z;
                    a_rad <= sphere_radius;
                end
                else if (op == OP_SOLVE_B)
                    impact_q.push_back(solve_impact('{pos_x, pos_y, pos_z},
                        '{vel_x, vel_y, vel_z}, '{acc_x, acc_y, acc_z}, sphere_radius));
            end
            // result beat
            if (out_valid && !out_stall)
            begin
                got.hit = collided;
                got.toi = time_offset;
                if (impact_q.size() == 0)
                begin
                    $display("%0t: unexpected result hit=%0b toi=%h", $time, got.hit, got.toi);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = impact_q.pop_front();
                    if (got.hit !== want.hit || got.toi !== want.toi)
                    begin
                        $display("%0t: mismatch expected hit=%0b toi=%h actual hit=%0b toi=%h",
                                 $time, want.hit, want.toi, got.hit, got.toi);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/sv/tb_sphere_pair_impact_time_top.sv
`timescale 1ns / 1ps

module tb_sphere_pair_impact_time_top;
    import spit_pkg::*;

    localparam logic OP_STORE_A = 1'b0;
    localparam logic OP_SOLVE_B = 1'b1;
    localparam int   CYCLE_LIMIT = 1500000;

    logic clk, rst_n;
    logic in_valid, in_stall, op;
    logic signed [DW-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;
    logic [RW-1:0] sphere_radius;
    logic out_valid, out_stall, collided;
    logic [TW-1:0] time_offset;
    logic cfg_valid, cfg_ready;
    logic [THR_W-1:0] cfg_data;
    int fail_count, pending_hits;
    int send_idle_pct, recv_idle_pct;
    int cycles;

    sphere_pair_impact_time_top uut (.*);
    sphere_pair_impact_time_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    function automatic logic signed [DW-1:0] rnd_val(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            default: return 0;
        endcase
    endfunction

    // valid stays up after the beat; the next beat or an idle cycle replaces it
    task automatic send_beat(input logic o, input logic signed [DW-1:0] p[3],
                             input logic signed [DW-1:0] v[3],
                             input logic signed [DW-1:0] a[3], input logic [RW-1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
        vel_x <= v[0]; vel_y <= v[1]; vel_z <= v[2];
        acc_x <= a[0]; acc_y <= a[1]; acc_z <= a[2];
        sphere_radius <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic random_beat(input logic o, input int mode);
        logic signed [DW-1:0] p[3], v[3], a[3];
        logic [RW-1:0] r;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = rnd_val(mode);
            v[i] = rnd_val(mode == 0 ? 0 : 1);
            a[i] = ($urandom_range(3) == 0) ? rnd_val(mode) : 0;
        end
        r = mode == 0 ? RW'($urandom) : RW'($urandom_range(0, 32'h0003_0000));
        send_beat(o, p, v, a, r);
    endtask

    task automatic drain_and_set(input logic [THR_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_hits != 0) @(posedge clk);
        repeat (250) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic signed [DW-1:0] zv[3], mx[3], mn[3], one[3];
        zv = '{0, 0, 0};
        mx = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        mn = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        one = '{32'sh0001_0000, 0, 0};
        rst_n = 0;
        in_valid = 0; op = 0;
        pos_x = 0; pos_y = 0; pos_z = 0; vel_x = 0; vel_y = 0; vel_z = 0;
        acc_x = 0; acc_y = 0; acc_z = 0; sphere_radius = 0;
        out_stall = 0; cfg_valid = 0; cfg_data = 0;
        send_idle_pct = 33; recv_idle_pct = 82;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset sphere A, extremes, linear and quadratic paths
        send_beat(OP_SOLVE_B, zv, zv, zv, 0);
        send_beat(OP_SOLVE_B, '{32'sh000A_0000, 0, 0}, '{-32'sh0001_0000, 0, 0}, zv,
                  31'h0001_0000);
        send_beat(OP_STORE_A, zv, zv, zv, 31'h0001_0000);
        send_beat(OP_SOLVE_B, '{32'sh0010_0000, 0, 0}, '{-32'sh0002_0000, 0, 0}, zv,
                  31'h0001_0000);
        send_beat(OP_SOLVE_B, '{32'sh0010_0000, 0, 0}, zv, '{-32'sh0001_0000, 0, 0},
                  31'h0000_8000);
        send_beat(OP_SOLVE_B, one, one, zv, 31'h0002_0000);
        send_beat(OP_SOLVE_B, one, zv, zv, 0);
        send_beat(OP_SOLVE_B, mx, mx, mx, '1);
        send_beat(OP_SOLVE_B, mn, mn, mn, '1);
        send_beat(OP_STORE_A, mn, mn, mn, '1);
        send_beat(OP_SOLVE_B, mx, mx, mx, '1);
        send_beat(OP_SOLVE_B, mx, zv, mn, 0);
        send_beat(OP_STORE_A, mx, mn, mx, 0);
        send_beat(OP_SOLVE_B, mn, mx, mn, '1);
        send_beat(OP_SOLVE_B, '{1, 0, 0}, '{-1, 0, 0}, zv, 0);
        send_beat(OP_STORE_A, zv, zv, zv, 0);
        send_beat(OP_SOLVE_B, '{32'sh0064_0000, 0, 0}, '{-32'sh0000_0001, 0, 0}, zv, 0);

        // random phases, each under its own threshold
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: drain_and_set(16'd0);
                1: drain_and_set(16'hFFFF);
                2: begin drain_and_set(THR_RESET); send_idle_pct = 82; recv_idle_pct = 33; end
                3: drain_and_set(16'd1);
                default: begin drain_and_set(16'($urandom)); send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < 166; n++)
            begin
                int mode;
                mode = $urandom_range(2);
                random_beat(OP_STORE_A, mode);
                random_beat(OP_SOLVE_B, mode);
                if ($urandom_range(9) == 0) random_beat(OP_SOLVE_B, mode);
            end
        end

        in_valid <= 1'b0;
        while (pending_hits != 0) @(posedge clk);
        repeat (250) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: sphere_pair_impact_time_top.f
+incdir+rtl/core
rtl/core/spit_pkg.sv
rtl/core/spit_datapath.sv
rtl/core/spit_ctrl.sv
rtl/core/sphere_pair_impact_time_top.sv
tb/sv/sphere_pair_impact_time_checker.sv
tb/sv/tb_sphere_pair_impact_time_top.sv
